// File: design/ppm_pkg.sv
// ----------------------------------------------------------------------------
// ppm_pkg: shared types and constants for the PPM stream decoder
// Holds the result kind and status codes and the command format that the
// parser hands to the output side.
// ----------------------------------------------------------------------------
package ppm_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int TOKEN_BUF = 16;
    localparam int CMDQ_DEPTH = 4;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC  = 3'd1;
    localparam logic [2:0] ST_BAD_WIDTH  = 3'd2;
    localparam logic [2:0] ST_BAD_HEIGHT = 3'd3;
    localparam logic [2:0] ST_BAD_MAXVAL = 3'd4;
    localparam logic [2:0] ST_BAD_RASTER = 3'd5;
    localparam logic [2:0] ST_SHORT      = 3'd6;

    // one unit of work for the output side
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] value;   // raw sample before scaling
        logic [12:0] width;
        logic [12:0] height;
        logic        binary;
        logic [15:0] maxval;  // header maxval, also the divisor for samples
        logic [2:0]  status;
    } cmd_t;

endpackage

// File: design/ppm_image_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// ppm_image_stream_decoder_top: PPM (P3/P6) byte stream decoder
// Parses the header, reports size, emits 8-bit scaled samples and a final
// status per file, without buffering the raster.
// ----------------------------------------------------------------------------
//
//  channel   handshake           payload
//  -------   -----------------   ------------------------------------------
//  input     push / full         in_byte, in_last
//  result    pop / empty         out_kind, out_sample, out_width, out_height,
//                                out_binary, out_maxval, out_status
//
//  Flow: the parser takes one byte per cycle while the queue has room for
//  two commands. Header and status results go straight to the output
//  register; each sample first runs through the 24-step serial divider for
//  sample*255/maxval, and no new command is taken until its result is registered.
//  Reset: rst_n clears parser state, queue pointers and the output valid flag.
//  Stalls: a withheld pop backs up the output register, then the queue, then
//  full; full is high whenever fewer than two queue slots are free, even for
//  bytes that would make no result.
// ----------------------------------------------------------------------------
module ppm_image_stream_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  out_kind,
    output logic [7:0]  out_sample,
    output logic [12:0] out_width,
    output logic [12:0] out_height,
    output logic        out_binary,
    output logic [15:0] out_maxval,
    output logic [2:0]  out_status
);
    import ppm_pkg::*;

    logic       take;       // input transfer this cycle
    logic [1:0] cmd_count;  // commands the current byte produces
    cmd_t       cmd0;
    cmd_t       cmd1;
    cmd_t       q_cmd;
    logic       q_valid;
    logic       q_room2;
    logic [2:0] q_count;
    logic       q_take;

    // a byte can make two results, so require two free slots
    assign full = !q_room2;
    assign take = push && !full;

    ppm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .cmd_count (cmd_count),
        .cmd0      (cmd0),
        .cmd1      (cmd1)
    );

    ppm_cmdq u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_count (cmd_count),
        .wr_cmd0  (cmd0),
        .wr_cmd1  (cmd1),
        .rd       (q_take),
        .rd_cmd   (q_cmd),
        .rd_valid (q_valid),
        .room2    (q_room2),
        .count    (q_count)
    );

    ppm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (q_cmd),
        .cmd_valid  (q_valid),
        .cmd_take   (q_take),
        .pop        (pop),
        .empty      (empty),
        .out_kind   (out_kind),
        .out_sample (out_sample),
        .out_width  (out_width),
        .out_height (out_height),
        .out_binary (out_binary),
        .out_maxval (out_maxval),
        .out_status (out_status)
    );

    // queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= 3'(CMDQ_DEPTH))
        else $error("command queue overflow");

    // a transfer never lands when fewer than two slots are free
    assert property (@(posedge clk) disable iff (!rst_n)
        take |-> q_count <= 3'd2)
        else $error("input taken without room");

    // only sample results carry a sample value
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_kind != KIND_SAMPLE) |-> out_sample == 8'd0)
        else $error("stray sample value");

    // header fields are zero except on a header result
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_kind != KIND_HEADER) |-> (out_width == 13'd0 && out_maxval == 16'd0))
        else $error("stray header fields");

endmodule

// File: design/ppm_cmdq.sv
// ----------------------------------------------------------------------------
// ppm_cmdq: command queue between parser and output side
// Four entries, up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module ppm_cmdq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       wr_count,
    input  ppm_pkg::cmd_t    wr_cmd0,
    input  ppm_pkg::cmd_t    wr_cmd1,
    input  logic             rd,
    output ppm_pkg::cmd_t    rd_cmd,
    output logic             rd_valid,
    output logic             room2,
    output logic [2:0]       count
);
    import ppm_pkg::*;

    cmd_t       entries_reg [CMDQ_DEPTH];
    logic [1:0] head_reg, head_next;
    logic [1:0] tail_reg, tail_next;
    logic [2:0] count_reg, count_next;
    logic       do_rd;

    assign do_rd    = rd && (count_reg != 3'd0);
    assign rd_cmd   = entries_reg[head_reg];
    assign rd_valid = (count_reg != 3'd0);
    assign room2    = (count_reg <= 3'd2);
    assign count    = count_reg;

    always_comb
    begin
        head_next  = head_reg + {1'b0, do_rd};
        tail_next  = tail_reg + wr_count;
        count_next = count_reg + {1'b0, wr_count} - {2'b0, do_rd};
    end

    always_ff @(posedge clk)
    begin
        if (wr_count != 2'd0)
        begin
            entries_reg[tail_reg] <= wr_cmd0;
        end
        if (wr_count == 2'd2)
        begin
            entries_reg[tail_reg + 2'd1] <= wr_cmd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: design/ppm_front.sv
// ----------------------------------------------------------------------------
// ppm_front: byte parser
// Tokenizes the header and ASCII raster, tracks the sample count and issues
// up to two commands per byte.
// ----------------------------------------------------------------------------
module ppm_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  logic [7:0]      in_byte,
    input  logic            in_last,
    output logic [1:0]      cmd_count,
    output ppm_pkg::cmd_t   cmd0,
    output ppm_pkg::cmd_t   cmd1
);
    import ppm_pkg::*;

    typedef enum logic [7:0] {
        PH_MAGIC  = 8'b0000_0001,
        PH_WIDTH  = 8'b0000_0010,
        PH_HEIGHT = 8'b0000_0100,
        PH_MAXVAL = 8'b0000_1000,
        PH_SKIP   = 8'b0001_0000,
        PH_RASTER = 8'b0010_0000,
        PH_DONE   = 8'b0100_0000,
        PH_ERROR  = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        phase_t      ph;
        logic        bin;
        logic        cmt;
        logic [15:0] tv;
        logic [3:0]  tl;
        logic        tb;
        logic [15:0] mc;
        logic [12:0] w;
        logic [12:0] h;
        logic [15:0] mv;
        logic [25:0] sl;
        logic [2:0]  ec;
    } fst_t;

    typedef struct packed {
        fst_t s;
        logic emit;
        cmd_t c;
    } fres_t;

    localparam logic [7:0]  CH_SP   = 8'h20;
    localparam logic [7:0]  CH_TAB  = 8'h09;
    localparam logic [7:0]  CH_CR   = 8'h0D;
    localparam logic [7:0]  CH_LF   = 8'h0A;
    localparam logic [7:0]  CH_HASH = 8'h23;
    localparam logic [7:0]  CH_0    = 8'h30;
    localparam logic [7:0]  CH_9    = 8'h39;
    localparam logic [15:0] MAGIC_P3 = 16'h5033;
    localparam logic [15:0] MAGIC_P6 = 16'h5036;
    localparam logic [16:0] DIM_MAX  = 17'(MAX_DIM);
    localparam logic [3:0]  TL_MAX   = 4'(TOKEN_BUF - 1);

    fst_t st_reg, st_next;

    function automatic fst_t f_reset();
        fst_t s;
        s    = '0;
        s.ph = PH_MAGIC;
        return s;
    endfunction

    function automatic logic f_tok(input fst_t s);
        return (s.ph == PH_MAGIC) || (s.ph == PH_WIDTH) || (s.ph == PH_HEIGHT) ||
               (s.ph == PH_MAXVAL) || ((s.ph == PH_RASTER) && !s.bin);
    endfunction

    function automatic logic f_ws(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic fres_t f_sample(input fst_t s, input logic [15:0] v);
        fres_t r;
        r         = '0;
        r.s       = s;
        r.emit    = 1'b1;
        r.c.kind  = KIND_SAMPLE;
        r.c.value = v;
        r.c.maxval = s.mv;
        if (s.sl != '0)
        begin
            r.s.sl = s.sl - 26'd1;
        end
        if (r.s.sl == '0)
        begin
            r.s.ph = PH_DONE;
        end
        return r;
    endfunction

    function automatic fres_t f_finish(input fst_t s);
        fres_t       r;
        logic [16:0] v;
        logic [25:0] wh;
        r     = '0;
        r.s   = s;
        v     = {1'b0, s.tv};
        r.s.tv = '0;
        r.s.tl = '0;
        r.s.tb = 1'b0;
        r.s.mc = '0;
        case (s.ph)
            PH_MAGIC:
            begin
                if (s.tl == 4'd2 && s.mc == MAGIC_P3)
                begin
                    r.s.bin = 1'b0;
                    r.s.ph  = PH_WIDTH;
                end
                else if (s.tl == 4'd2 && s.mc == MAGIC_P6)
                begin
                    r.s.bin = 1'b1;
                    r.s.ph  = PH_WIDTH;
                end
                else
                begin
                    r.s.ph = PH_ERROR;
                    r.s.ec = ST_BAD_MAGIC;
                end
            end
            PH_WIDTH:
            begin
                if (s.tb || v == '0 || v > DIM_MAX)
                begin
                    r.s.ph = PH_ERROR;
                    r.s.ec = ST_BAD_WIDTH;
                end
                else
                begin
                    r.s.w  = v[12:0];
                    r.s.ph = PH_HEIGHT;
                end
            end
            PH_HEIGHT:
            begin
                if (s.tb || v == '0 || v > DIM_MAX)
                begin
                    r.s.ph = PH_ERROR;
                    r.s.ec = ST_BAD_HEIGHT;
                end
                else
                begin
                    r.s.h  = v[12:0];
                    r.s.ph = PH_MAXVAL;
                end
            end
            PH_MAXVAL:
            begin
                if (s.tb || v == '0)
                begin
                    r.s.ph = PH_ERROR;
                    r.s.ec = ST_BAD_MAXVAL;
                end
                else
                begin
                    wh          = 26'(s.w) * 26'(s.h);
                    r.s.mv      = s.tv;
                    r.s.sl      = wh + {wh[24:0], 1'b0};
                    r.emit      = 1'b1;
                    r.c.kind    = KIND_HEADER;
                    r.c.width   = s.w;
                    r.c.height  = s.h;
                    r.c.binary  = s.bin;
                    r.c.maxval  = s.tv;
                    r.s.ph      = s.bin ? PH_SKIP : PH_RASTER;
                end
            end
            PH_RASTER:
            begin
                if (s.tb)
                begin
                    r.s.ph = PH_ERROR;
                    r.s.ec = ST_BAD_RASTER;
                end
                else
                begin
                    r = f_sample(r.s, s.tv);
                end
            end
            default:
            begin
                r.emit = 1'b0;
            end
        endcase
        return r;
    endfunction

    function automatic fres_t f_raw(input fst_t s, input logic [7:0] c);
        fres_t r;
        r   = '0;
        r.s = s;
        if (s.ph == PH_SKIP && f_ws(c))
        begin
            return r;
        end
        r.s.ph = PH_RASTER;
        return f_sample(r.s, {8'd0, c});
    endfunction

    always_comb
    begin
        fst_t        s;
        fres_t       r;
        logic [1:0]  n;
        logic [19:0] t;
        logic [2:0]  sts;
        cmd_t        stc;
        s   = st_reg;
        r   = '0;
        n   = 2'd0;
        t   = '0;
        sts = ST_OK;
        stc = '0;
        cmd0 = '0;
        cmd1 = '0;

        if (f_tok(s))
        begin
            if (s.cmt)
            begin
                if (in_byte == CH_LF)
                begin
                    s.cmt = 1'b0;
                end
            end
            else if (f_ws(in_byte))
            begin
                if (s.tl != '0)
                begin
                    r = f_finish(s);
                    s = r.s;
                end
            end
            else if (in_byte == CH_HASH)
            begin
                if (s.tl != '0)
                begin
                    r = f_finish(s);
                    s = r.s;
                    if (r.emit)
                    begin
                        cmd0 = r.c;
                        n    = 2'd1;
                    end
                end
                r = '0;
                if (s.ph == PH_SKIP)
                begin
                    // '#' right after a P6 maxval is the first raster byte
                    r = f_raw(s, in_byte);
                    s = r.s;
                end
                else if (f_tok(s))
                begin
                    s.cmt = 1'b1;
                end
            end
            else
            begin
                if (s.tl < 4'd2)
                begin
                    s.mc = {s.mc[7:0], in_byte};
                end
                if (!s.tb)
                begin
                    if (in_byte < CH_0 || in_byte > CH_9)
                    begin
                        s.tb = 1'b1;
                    end
                    else
                    begin
                        t = {s.tv, 3'b0} + {3'b0, s.tv, 1'b0} + 20'(in_byte - CH_0);
                        if (t > 20'hFFFF)
                        begin
                            s.tb = 1'b1;
                        end
                        else
                        begin
                            s.tv = t[15:0];
                        end
                    end
                end
                s.tl = s.tl + 4'd1;
                if (s.tl >= TL_MAX)
                begin
                    r = f_finish(s);
                    s = r.s;
                end
            end
        end
        else if (s.ph == PH_SKIP || s.ph == PH_RASTER)
        begin
            r = f_raw(s, in_byte);
            s = r.s;
        end

        if (r.emit)
        begin
            if (n == 2'd0)
            begin
                cmd0 = r.c;
            end
            else
            begin
                cmd1 = r.c;
            end
            n = n + 2'd1;
        end

        if (in_last)
        begin
            if (f_tok(s) && s.tl != '0)
            begin
                r = f_finish(s);
                s = r.s;
                if (r.emit)
                begin
                    if (n == 2'd0)
                    begin
                        cmd0 = r.c;
                    end
                    else
                    begin
                        cmd1 = r.c;
                    end
                    n = n + 2'd1;
                end
            end
            if (s.ph == PH_ERROR)
            begin
                sts = s.ec;
            end
            else if (s.ph == PH_DONE)
            begin
                sts = ST_OK;
            end
            else
            begin
                sts = ST_SHORT;
            end
            stc.kind   = KIND_STATUS;
            stc.status = sts;
            // status takes the first slot, or the second when a result already exists
            if (n == 2'd0)
            begin
                cmd0 = stc;
                n    = 2'd1;
            end
            else
            begin
                cmd1 = stc;
                n    = 2'd2;
            end
            s = f_reset();
        end

        cmd_count = take ? n : 2'd0;
        st_next   = take ? s : st_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= f_reset();
        end
        else
        begin
            st_reg <= st_next;
        end
    end

endmodule

// File: design/ppm_back.sv
// ----------------------------------------------------------------------------
// ppm_back: result side
// Scales samples by 255/maxval with a bit-serial divider and holds each
// result in an output register.
// ----------------------------------------------------------------------------
module ppm_back (
    input  logic            clk,
    input  logic            rst_n,
    input  ppm_pkg::cmd_t   cmd,
    input  logic            cmd_valid,
    output logic            cmd_take,
    input  logic            pop,
    output logic            empty,
    output logic [1:0]      out_kind,
    output logic [7:0]      out_sample,
    output logic [12:0]     out_width,
    output logic [12:0]     out_height,
    output logic            out_binary,
    output logic [15:0]     out_maxval,
    output logic [2:0]      out_status
);
    import ppm_pkg::*;

    typedef enum logic [2:0] {
        BK_IDLE = 3'b001,
        BK_DIV  = 3'b010,
        BK_HOLD = 3'b100
    } bk_state_t;

    localparam int DVD_W = 24;
    localparam logic [4:0] LAST_STEP = 5'(DVD_W - 1);

    bk_state_t   state_reg, state_next;
    logic [23:0] dvd_reg, dvd_next;      // dividend, quotient shifts in
    logic [15:0] rem_reg, rem_next;
    logic [15:0] div_reg, div_next;
    logic [4:0]  step_reg, step_next;
    logic        ov_reg, ov_next;
    cmd_t        oc_reg, oc_next;
    logic [7:0]  os_reg, os_next;
    logic        out_free;
    logic [16:0] rem2;
    logic [16:0] rem_sub;

    assign out_free = !ov_reg || pop;
    assign rem2     = {rem_reg, dvd_reg[23]};
    assign rem_sub  = rem2 - {1'b0, div_reg};

    always_comb
    begin
        state_next = state_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        step_next  = step_reg;
        oc_next    = oc_reg;
        os_next    = os_reg;
        ov_next    = ov_reg && !pop;
        cmd_take   = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_take = 1'b1;
                    if (cmd.kind == KIND_SAMPLE)
                    begin
                        // v*255 = (v<<8) - v
                        dvd_next   = {cmd.value, 8'd0} - {8'd0, cmd.value};
                        div_next   = cmd.maxval;
                        rem_next   = '0;
                        step_next  = '0;
                        state_next = BK_DIV;
                    end
                    else
                    begin
                        oc_next = cmd;
                        os_next = '0;
                        ov_next = 1'b1;
                    end
                end
            end
            BK_DIV:
            begin
                if (!rem_sub[16])
                begin
                    rem_next = rem_sub[15:0];
                    dvd_next = {dvd_reg[22:0], 1'b1};
                end
                else
                begin
                    rem_next = rem2[15:0];
                    dvd_next = {dvd_reg[22:0], 1'b0};
                end
                step_next = step_reg + 5'd1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = BK_HOLD;
                end
            end
            BK_HOLD:
            begin
                if (out_free)
                begin
                    oc_next      = '0;
                    oc_next.kind = KIND_SAMPLE;
                    os_next      = (div_reg == '0) ? 8'd0 : dvd_reg[7:0];
                    ov_next      = 1'b1;
                    state_next   = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        oc_reg   <= oc_next;
        os_reg   <= os_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            step_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            ov_reg    <= ov_next;
        end
    end

    assign empty      = !ov_reg;
    assign out_kind   = oc_reg.kind;
    assign out_sample = os_reg;
    assign out_width  = oc_reg.width;
    assign out_height = oc_reg.height;
    assign out_binary = oc_reg.binary;
    assign out_maxval = oc_reg.maxval;
    assign out_status = oc_reg.status;

endmodule
